FILE: src/anos_pkg.sv
// Shared constants, state and command/status types of the active note-off scheduler.
package anos_pkg;

    localparam int MAX_NOTES = 32;
    localparam int IDX_W     = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CNT_W     = $clog2(MAX_NOTES + 1);

    localparam int BEAT_W    = 32;
    localparam int FRAME_W   = 32;
    localparam int PITCH_W   = 7;
    localparam int CHAN_W    = 4;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 8;
    localparam int FRAC_SHIFT = 28;

    localparam int S_DATA_W  = 176;
    localparam int M_DATA_W  = 48;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd2;

    localparam logic [STATUS_W-1:0] NOTE_OFF_STATUS = 8'h80;
    localparam logic [STATUS_W-1:0] CHAN_MASK       = 8'h0F;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV_RD,
        ST_ADV_CHK,
        ST_ADV_MUL,
        ST_ADV_EMIT,
        ST_FLS_RD,
        ST_FLS_CHK,
        ST_FLS_EMIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic ld_item;     // capture the accepted item
        logic add_wr;      // store the incoming note at the fill position
        logic idx_top;     // index <= count - 1
        logic idx_zero;    // index <= 0
        logic idx_dec;
        logic idx_inc;
        logic rd_idx;      // read table entry at index
        logic rd_last;     // read table entry at count - 1
        logic latch_entry; // capture read data and the beat offset
        logic clr_prod;    // scaled offset <= 0
        logic mul;         // scaled offset <= offset * samples_per_beat >> 28
        logic swap_wr;     // move last entry into index, count <= count - 1
        logic emit;        // push held note-off out, hold the new candidate
        logic fin_push;    // push held note-off out as the final one
        logic clr_count;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic count_zero;
        logic count_full;
        logic idx_zero;
        logic idx_at_top;
        logic expire;
        logic out_free;
        logic pend_valid;
    } sts_t;

endpackage

FILE: src/anos_ctrl.sv
// Controller state machine of the active note-off scheduler.
module anos_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    output anos_pkg::cmd_t               cmd,
    input  anos_pkg::sts_t               sts
);

    anos_pkg::state_t state_reg, state_next;
    logic             accept;
    logic             can_emit;

    assign s_tready = (state_reg == anos_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // A new candidate may only displace the held one once the output can take it.
    assign can_emit = !sts.pend_valid || sts.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= anos_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            anos_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd.ld_item = 1'b1;
                    case (sts.op)
                        anos_pkg::OP_ADD: begin
                            cmd.add_wr = !sts.count_full;
                        end
                        anos_pkg::OP_ADVANCE: begin
                            if (!sts.count_zero) begin
                                cmd.idx_top = 1'b1;
                                state_next  = anos_pkg::ST_ADV_RD;
                            end
                        end
                        anos_pkg::OP_FLUSH: begin
                            if (!sts.count_zero) begin
                                cmd.idx_zero = 1'b1;
                                state_next   = anos_pkg::ST_FLS_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            anos_pkg::ST_ADV_RD: begin
                cmd.rd_idx = 1'b1;
                state_next = anos_pkg::ST_ADV_CHK;
            end
            anos_pkg::ST_ADV_CHK: begin
                cmd.latch_entry = 1'b1;
                if (sts.expire) begin
                    state_next = anos_pkg::ST_ADV_MUL;
                end else if (sts.idx_zero) begin
                    state_next = anos_pkg::ST_FIN;
                end else begin
                    cmd.idx_dec = 1'b1;
                    state_next  = anos_pkg::ST_ADV_RD;
                end
            end
            anos_pkg::ST_ADV_MUL: begin
                cmd.mul     = 1'b1;
                cmd.rd_last = 1'b1;
                state_next  = anos_pkg::ST_ADV_EMIT;
            end
            anos_pkg::ST_ADV_EMIT: begin
                if (can_emit) begin
                    cmd.emit    = 1'b1;
                    cmd.swap_wr = 1'b1;
                    if (sts.idx_zero) begin
                        state_next = anos_pkg::ST_FIN;
                    end else begin
                        cmd.idx_dec = 1'b1;
                        state_next  = anos_pkg::ST_ADV_RD;
                    end
                end
            end
            anos_pkg::ST_FLS_RD: begin
                cmd.rd_idx = 1'b1;
                state_next = anos_pkg::ST_FLS_CHK;
            end
            anos_pkg::ST_FLS_CHK: begin
                cmd.latch_entry = 1'b1;
                cmd.clr_prod    = 1'b1;
                state_next      = anos_pkg::ST_FLS_EMIT;
            end
            anos_pkg::ST_FLS_EMIT: begin
                if (can_emit) begin
                    cmd.emit = 1'b1;
                    if (sts.idx_at_top) begin
                        cmd.clr_count = 1'b1;
                        state_next    = anos_pkg::ST_FIN;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = anos_pkg::ST_FLS_RD;
                    end
                end
            end
            anos_pkg::ST_FIN: begin
                if (!sts.pend_valid) begin
                    state_next = anos_pkg::ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.fin_push = 1'b1;
                    state_next   = anos_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = anos_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/anos_dp.sv
// Datapath of the active note-off scheduler: note table, offset scaling, result registers.
module anos_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  anos_pkg::cmd_t                   cmd,
    output anos_pkg::sts_t                   sts,
    input  logic [anos_pkg::OP_W-1:0]        in_op,
    input  logic [anos_pkg::PITCH_W-1:0]     in_pitch,
    input  logic [anos_pkg::CHAN_W-1:0]      in_channel,
    input  logic [anos_pkg::BEAT_W-1:0]      in_end_beat,
    input  logic [anos_pkg::BEAT_W-1:0]      in_from_beat,
    input  logic [anos_pkg::BEAT_W-1:0]      in_up_to_beat,
    input  logic [anos_pkg::FRAME_W-1:0]     in_frame_base,
    input  logic [anos_pkg::BEAT_W-1:0]      in_samples_per_beat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [anos_pkg::STATUS_W-1:0]    out_status_byte,
    output logic [anos_pkg::PITCH_W-1:0]     out_note_pitch,
    output logic [anos_pkg::FRAME_W-1:0]     out_frame,
    output logic                             out_last
);

    localparam int ENT_W = anos_pkg::PITCH_W + anos_pkg::CHAN_W + anos_pkg::BEAT_W;
    localparam int PROD_W = 2 * anos_pkg::BEAT_W;

    // Note table: pitch, channel and end beat packed per entry.
    logic [ENT_W-1:0] mem [anos_pkg::MAX_NOTES];
    logic [ENT_W-1:0] rdata_reg;

    logic [anos_pkg::BEAT_W-1:0]  from_reg, upto_reg, spb_reg;
    logic [anos_pkg::FRAME_W-1:0] base_reg;

    logic [anos_pkg::CNT_W-1:0] count_reg;
    logic [anos_pkg::IDX_W-1:0] idx_reg;
    logic [anos_pkg::IDX_W-1:0] last_idx;

    logic [anos_pkg::PITCH_W-1:0] ent_pitch_reg;
    logic [anos_pkg::CHAN_W-1:0]  ent_chan_reg;
    logic [anos_pkg::BEAT_W-1:0]  off_reg;
    logic [anos_pkg::FRAME_W-1:0] scaled_reg;
    logic [PROD_W-1:0]            prod;

    logic [anos_pkg::PITCH_W-1:0]  rd_pitch;
    logic [anos_pkg::CHAN_W-1:0]   rd_chan;
    logic [anos_pkg::BEAT_W-1:0]   rd_end;

    logic                          pend_valid_reg;
    logic [anos_pkg::STATUS_W-1:0] pend_status_reg;
    logic [anos_pkg::PITCH_W-1:0]  pend_pitch_reg;
    logic [anos_pkg::FRAME_W-1:0]  pend_frame_reg;
    logic                          out_valid_reg;
    logic [anos_pkg::STATUS_W-1:0] out_status_reg;
    logic [anos_pkg::PITCH_W-1:0]  out_pitch_reg;
    logic [anos_pkg::FRAME_W-1:0]  out_frame_reg;
    logic                          out_last_reg;

    logic [anos_pkg::STATUS_W-1:0] cand_status;
    logic [anos_pkg::FRAME_W-1:0]  cand_frame;

    assign last_idx = anos_pkg::IDX_W'(count_reg - anos_pkg::CNT_W'(1));
    assign rd_pitch = rdata_reg[ENT_W-1 -: anos_pkg::PITCH_W];
    assign rd_chan  = rdata_reg[anos_pkg::BEAT_W +: anos_pkg::CHAN_W];
    assign rd_end   = rdata_reg[anos_pkg::BEAT_W-1:0];

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (cmd.add_wr) begin
            mem[count_reg[anos_pkg::IDX_W-1:0]] <= {in_pitch, in_channel, in_end_beat};
        end else if (cmd.swap_wr) begin
            mem[idx_reg] <= rdata_reg;
        end
        if (cmd.rd_idx) begin
            rdata_reg <= mem[idx_reg];
        end else if (cmd.rd_last) begin
            rdata_reg <= mem[last_idx];
        end
    end

    // Captured item fields.
    always_ff @(posedge aclk) begin
        if (cmd.ld_item) begin
            from_reg <= in_from_beat;
            upto_reg <= in_up_to_beat;
            base_reg <= in_frame_base;
            spb_reg  <= in_samples_per_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.add_wr) begin
            count_reg <= count_reg + anos_pkg::CNT_W'(1);
        end else if (cmd.swap_wr) begin
            count_reg <= count_reg - anos_pkg::CNT_W'(1);
        end else if (cmd.clr_count) begin
            count_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.idx_top) begin
            idx_reg <= last_idx;
        end else if (cmd.idx_zero) begin
            idx_reg <= '0;
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_reg - anos_pkg::IDX_W'(1);
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + anos_pkg::IDX_W'(1);
        end
    end

    // Entry capture, beat offset, then the registered product.
    assign prod = PROD_W'(off_reg) * PROD_W'(spb_reg);

    always_ff @(posedge aclk) begin
        if (cmd.latch_entry) begin
            ent_pitch_reg <= rd_pitch;
            ent_chan_reg  <= rd_chan;
            off_reg       <= (rd_end > from_reg) ? (rd_end - from_reg) : '0;
        end
        if (cmd.clr_prod) begin
            scaled_reg <= '0;
        end else if (cmd.mul) begin
            scaled_reg <= prod[anos_pkg::FRAC_SHIFT +: anos_pkg::FRAME_W];
        end
    end

    assign cand_status = anos_pkg::NOTE_OFF_STATUS |
                         (anos_pkg::STATUS_W'(ent_chan_reg) & anos_pkg::CHAN_MASK);
    assign cand_frame  = base_reg + scaled_reg;

    // One note-off is held back until the next one or the end of the walk
    // shows whether it is the final one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.fin_push) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            pend_status_reg <= cand_status;
            pend_pitch_reg  <= ent_pitch_reg;
            pend_frame_reg  <= cand_frame;
        end
    end

    logic push;
    assign push = (cmd.emit && pend_valid_reg) || cmd.fin_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_status_reg <= pend_status_reg;
            out_pitch_reg  <= pend_pitch_reg;
            out_frame_reg  <= pend_frame_reg;
            out_last_reg   <= cmd.fin_push;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status_byte = out_status_reg;
    assign out_note_pitch  = out_pitch_reg;
    assign out_frame       = out_frame_reg;
    assign out_last        = out_last_reg;

    assign sts.op         = in_op;
    assign sts.count_zero = (count_reg == '0);
    assign sts.count_full = (count_reg >= anos_pkg::CNT_W'(anos_pkg::MAX_NOTES));
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.idx_at_top = (idx_reg == last_idx);
    assign sts.expire     = (rd_end <= upto_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.pend_valid = pend_valid_reg;

endmodule

FILE: src/active_note_off_scheduler_core.sv
// Top level of the active note-off scheduler: stream ports, controller and datapath.
//
// One input transfer carries one operation, chosen by s_tuser: add a note, advance
// and expire notes ending at or before up_to_beat, or flush every stored note.
// Each expired or flushed note leaves as one result transfer on the m_ side, a
// MIDI note-off with its sample frame; m_tlast marks the final one of an item.
// An add is taken in its accept cycle and gives no result; a full table drops it.
// An advance walks the table from the top entry down: read and compare each entry,
// and for an expired one multiply and write back; a flush walks it from entry zero
// (read, capture, emit). The walk over the note table sets how long an item takes,
// and no new item is taken until the walk is done.
// The last note-off of an item is held until the walk ends and is pushed in the
// final state after the walk; s_tready rises again once it sits in the output
// register. When the receiver stalls, the walk waits at the next note-off, and
// the held results stay stable. Reset clears the note count, the handshake and the
// state machine; table contents need no clearing.
module active_note_off_scheduler_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: pitch[6:0], channel[10:7], end_beat[42:11],
    // from_beat[74:43], up_to_beat[106:75], frame_base[138:107],
    // samples_per_beat[170:139], zero fill up to bit 175.
    input  logic [anos_pkg::S_DATA_W-1:0]     s_tdata,
    // s_tuser: op[1:0].
    input  logic [anos_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: status_byte[7:0], note_pitch[14:8], frame[46:15],
    // zero fill at bit 47.
    output logic [anos_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);

    anos_pkg::cmd_t cmd;
    anos_pkg::sts_t sts;

    logic [anos_pkg::STATUS_W-1:0] status_byte;
    logic [anos_pkg::PITCH_W-1:0]  note_pitch;
    logic [anos_pkg::FRAME_W-1:0]  frame;

    anos_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    anos_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .in_op               (s_tuser),
        .in_pitch            (s_tdata[6:0]),
        .in_channel          (s_tdata[10:7]),
        .in_end_beat         (s_tdata[42:11]),
        .in_from_beat        (s_tdata[74:43]),
        .in_up_to_beat       (s_tdata[106:75]),
        .in_frame_base       (s_tdata[138:107]),
        .in_samples_per_beat (s_tdata[170:139]),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .out_status_byte     (status_byte),
        .out_note_pitch      (note_pitch),
        .out_frame           (frame),
        .out_last            (m_tlast)
    );

    assign m_tdata = {1'b0, frame, note_pitch, status_byte};

endmodule

FILE: test/tb.sv
// Self-checking testbench for the active note-off scheduler core.
`timescale 1ns / 1ps

module tb;

    // The fourth operation code has no name in the package; the block ignores it.
    localparam logic [anos_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 270;

    typedef struct packed {
        logic [anos_pkg::OP_W-1:0]    op;
        logic [anos_pkg::PITCH_W-1:0] pitch;
        logic [anos_pkg::CHAN_W-1:0]  chan;
        logic [31:0]                  end_beat;
        logic [31:0]                  from_beat;
        logic [31:0]                  up_to_beat;
        logic [31:0]                  frame_base;
        logic [31:0]                  spb;
    } note_cmd_t;

    typedef struct packed {
        logic [anos_pkg::STATUS_W-1:0] status;
        logic [anos_pkg::PITCH_W-1:0]  pitch;
        logic [anos_pkg::FRAME_W-1:0]  frame;
        logic                          is_last;
    } note_off_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [anos_pkg::S_DATA_W-1:0]   s_tdata;
    logic [anos_pkg::OP_W-1:0]       s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [anos_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tlast;

    // Shadow copy of the note table, updated as each transfer is accepted.
    logic [anos_pkg::PITCH_W-1:0] sounding_pitch [anos_pkg::MAX_NOTES];
    logic [anos_pkg::CHAN_W-1:0]  sounding_chan  [anos_pkg::MAX_NOTES];
    logic [31:0]                  sounding_end   [anos_pkg::MAX_NOTES];
    int                           sounding_count;

    note_off_t note_off_q[$];
    int        mismatch_count;
    int        src_gap_pct;
    int        sink_stall_pct;
    logic [31:0] beat_now;

    active_note_off_scheduler_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("active_note_off_scheduler_core: mismatch");
        $finish;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic note_cmd_t make_cmd(logic [anos_pkg::OP_W-1:0] op,
                                           logic [anos_pkg::PITCH_W-1:0] pitch,
                                           logic [anos_pkg::CHAN_W-1:0] chan,
                                           logic [31:0] end_beat,
                                           logic [31:0] from_beat, logic [31:0] up_to_beat,
                                           logic [31:0] frame_base, logic [31:0] spb);
        note_cmd_t c;
        c.op = op;
        c.pitch = pitch;
        c.chan = chan;
        c.end_beat = end_beat;
        c.from_beat = from_beat;
        c.up_to_beat = up_to_beat;
        c.frame_base = frame_base;
        c.spb = spb;
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Applies one accepted command to the shadow table and queues the note-offs it
    // releases, in the order the block must send them.
    function automatic void predict_note_offs(note_cmd_t c);
        note_off_t   n;
        int          first_new;
        int          idx;
        logic [31:0] offset;
        logic [63:0] scaled;
        first_new = note_off_q.size();
        case (c.op)
            anos_pkg::OP_ADD: begin
                // A full table drops the note without a trace.
                if (sounding_count < anos_pkg::MAX_NOTES) begin
                    sounding_pitch[anos_pkg::IDX_W'(sounding_count)] = c.pitch;
                    sounding_chan[anos_pkg::IDX_W'(sounding_count)] = c.chan;
                    sounding_end[anos_pkg::IDX_W'(sounding_count)] = c.end_beat;
                    sounding_count++;
                end
            end
            anos_pkg::OP_ADVANCE: begin
                // Walk from the top entry down; an expired entry is replaced by the
                // last one, which is not looked at again in this walk.
                idx = sounding_count;
                while (idx > 0) begin
                    idx--;
                    if (sounding_end[anos_pkg::IDX_W'(idx)] <= c.up_to_beat) begin
                        n.frame = c.frame_base;
                        if (sounding_end[anos_pkg::IDX_W'(idx)] > c.from_beat) begin
                            offset = sounding_end[anos_pkg::IDX_W'(idx)] - c.from_beat;
                            scaled = {32'd0, offset} * {32'd0, c.spb};
                            n.frame = c.frame_base
                                    + scaled[anos_pkg::FRAC_SHIFT +: anos_pkg::FRAME_W];
                        end
                        n.status = anos_pkg::NOTE_OFF_STATUS
                                 | ({4'd0, sounding_chan[anos_pkg::IDX_W'(idx)]}
                                    & anos_pkg::CHAN_MASK);
                        n.pitch = sounding_pitch[anos_pkg::IDX_W'(idx)];
                        n.is_last = 1'b0;
                        note_off_q.push_back(n);
                        sounding_count--;
                        sounding_pitch[anos_pkg::IDX_W'(idx)] =
                            sounding_pitch[anos_pkg::IDX_W'(sounding_count)];
                        sounding_chan[anos_pkg::IDX_W'(idx)] =
                            sounding_chan[anos_pkg::IDX_W'(sounding_count)];
                        sounding_end[anos_pkg::IDX_W'(idx)] =
                            sounding_end[anos_pkg::IDX_W'(sounding_count)];
                    end
                end
            end
            anos_pkg::OP_FLUSH: begin
                for (idx = 0; idx < sounding_count; idx++) begin
                    n.status = anos_pkg::NOTE_OFF_STATUS
                             | ({4'd0, sounding_chan[anos_pkg::IDX_W'(idx)]}
                                & anos_pkg::CHAN_MASK);
                    n.pitch = sounding_pitch[anos_pkg::IDX_W'(idx)];
                    n.frame = c.frame_base;
                    n.is_last = 1'b0;
                    note_off_q.push_back(n);
                end
                sounding_count = 0;
            end
            default: begin
            end
        endcase
        if (note_off_q.size() > first_new) begin
            n = note_off_q.pop_back();
            n.is_last = 1'b1;
            note_off_q.push_back(n);
        end
    endfunction

    // Drives one command at the falling edge and holds it until the transfer.
    task automatic send_item(note_cmd_t c);
        int gap;
        gap = ($urandom_range(0, 99) < src_gap_pct) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        // Five zero bits fill the top of tdata up to a whole byte.
        s_tdata = {5'd0, c.spb, c.frame_base, c.up_to_beat, c.from_beat, c.end_beat,
                   c.chan, c.pitch};
        s_tuser = c.op;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_note_offs(c);
        @(negedge aclk);
    endtask

    // Receiver side: ready changes at the falling edge, with random stall runs.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) < sink_stall_pct) begin
                    stall_left = idle_len();
                end
            end
        end
    end

    // Every result transfer is compared with the oldest pending note-off.
    always @(posedge aclk) begin
        note_off_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (note_off_q.size() == 0) begin
                report_mismatch("note-off with none pending, frame", 32'd0, m_tdata[46:15]);
            end else begin
                want = note_off_q.pop_front();
                if (m_tdata[7:0] !== want.status) begin
                    report_mismatch("status byte", 32'(want.status), 32'(m_tdata[7:0]));
                end
                if (m_tdata[14:8] !== want.pitch) begin
                    report_mismatch("note pitch", 32'(want.pitch), 32'(m_tdata[14:8]));
                end
                if (m_tdata[46:15] !== want.frame) begin
                    report_mismatch("frame", want.frame, m_tdata[46:15]);
                end
                if (m_tlast !== want.is_last) begin
                    report_mismatch("tlast", 32'(want.is_last), 32'(m_tlast));
                end
            end
        end
    end

    // Extremes of every field, each operation and each special case, one at a time.
    task automatic test_corner_cases();
        src_gap_pct = 30;
        sink_stall_pct = 30;
        // Nothing to release on an empty table, and the unused code is ignored.
        send_item(make_cmd(anos_pkg::OP_FLUSH, 7'h7F, 4'hF, '1, '1, '1, '1, '1));
        send_item(make_cmd(anos_pkg::OP_ADVANCE, 7'h00, 4'h0, 0, 0, '1, 32'h1234,
                           32'h1000));
        send_item(make_cmd(OP_UNUSED, 7'h7F, 4'hF, '1, '1, '1, '1, '1));
        send_item(make_cmd(anos_pkg::OP_ADD, 7'h7F, 4'hF, 32'hFFFF_FFFF, 0, 0, 0, 0));
        send_item(make_cmd(anos_pkg::OP_ADD, 7'h00, 4'h0, 32'h0000_0000, '1, '1, '1, '1));
        send_item(make_cmd(anos_pkg::OP_ADD, 7'h55, 4'hA, 32'h0001_8000, 0, 0, 0, 0));
        send_item(make_cmd(anos_pkg::OP_ADD, 7'h2A, 4'h5, 32'h0002_0000, 0, 0, 0, 0));
        // The ignored code must leave the table as it is, whatever its fields hold.
        send_item(make_cmd(OP_UNUSED, 7'h11, 4'h3, 0, 0, '1, '1, '1));
        // End beat at or before the window start: the note-off lands on frame_base.
        send_item(make_cmd(anos_pkg::OP_ADVANCE, 7'd0, 4'd0, 0, 32'h0001_0000,
                           32'h0001_0000, 32'h0000_0100, 32'h0BB8_0000));
        // Largest samples_per_beat with frame_base near the top: the sum wraps.
        send_item(make_cmd(anos_pkg::OP_ADVANCE, 7'd0, 4'd0, 0, 32'h0000_0000,
                           32'h0002_0000, 32'hFFFF_FFF0, 32'hFFFF_FFFF));
        // One step short of the last note: nothing expires.
        send_item(make_cmd(anos_pkg::OP_ADVANCE, 7'd0, 4'd0, 0, 0, 32'hFFFF_FFFE, 32'h55,
                           32'h1000));
        // Largest offset times largest rate: the shifted product is cut to 32 bits.
        send_item(make_cmd(anos_pkg::OP_ADVANCE, 7'd0, 4'd0, 0, 0, 32'hFFFF_FFFF,
                           32'h0000_007B, 32'hFFFF_FFFF));
        // End beat equal to the window start: offset zero, frame_base itself.
        send_item(make_cmd(anos_pkg::OP_ADD, 7'h3C, 4'h9, 32'h0004_0000, 0, 0, 0, 0));
        send_item(make_cmd(anos_pkg::OP_ADVANCE, 7'd0, 4'd0, 0, 32'h0004_0000,
                           32'h0004_0000, 32'hAAAA_AAAA, 32'hFFFF_FFFF));
        // Smallest positive offset at a samples_per_beat of 0x1000 truncates to zero.
        send_item(make_cmd(anos_pkg::OP_ADD, 7'h40, 4'h6, 32'h0004_0001, 0, 0, 0, 0));
        send_item(make_cmd(anos_pkg::OP_ADVANCE, 7'd0, 4'd0, 0, 32'h0004_0000,
                           32'h0004_0001, 32'h0000_1000, 32'h0000_1000));
        // A zero rate puts every note-off on frame_base.
        send_item(make_cmd(anos_pkg::OP_ADD, 7'h01, 4'h1, 32'h0009_0000, 0, 0, 0, 0));
        send_item(make_cmd(anos_pkg::OP_ADVANCE, 7'd0, 4'd0, 0, 32'h0001_0000,
                           32'h0010_0000, 32'h0000_4000, 32'h0000_0000));
        // Flush releases entries in index order at frame_base.
        send_item(make_cmd(anos_pkg::OP_ADD, 7'h10, 4'h2, 32'h7000_0000, 0, 0, 0, 0));
        send_item(make_cmd(anos_pkg::OP_ADD, 7'h20, 4'hC, 32'h0000_0001, 0, 0, 0, 0));
        send_item(make_cmd(anos_pkg::OP_ADD, 7'h30, 4'h7, 32'hFFFF_0000, 0, 0, 0, 0));
        send_item(make_cmd(anos_pkg::OP_FLUSH, 7'd0, 4'd0, 0, 0, 0, 32'hFFFF_FFFF, 0));
    endtask

    // Fills the table, adds past the top so notes are dropped, expires part of it, adds one more, then flushes it.
    task automatic test_full_table();
        int k;
        logic [31:0] spb;
        src_gap_pct = 10;
        sink_stall_pct = 20;
        for (k = 0; k < anos_pkg::MAX_NOTES + 3; k++) begin
            send_item(make_cmd(anos_pkg::OP_ADD, 7'($urandom), 4'($urandom),
                               $urandom_range(0, 32'h0040_0000), $urandom, $urandom,
                               $urandom, $urandom));
        end
        spb = $urandom_range(32'h0006_4000, 32'h0BB8_0000);
        send_item(make_cmd(anos_pkg::OP_ADVANCE, 7'd0, 4'd0, 0, 32'h0010_0000,
                           32'h0020_0000, $urandom, spb));
        send_item(make_cmd(anos_pkg::OP_ADD, 7'($urandom), 4'($urandom), $urandom,
                           0, 0, 0, 0));
        send_item(make_cmd(anos_pkg::OP_FLUSH, 7'd0, 4'd0, 0, 0, 0, $urandom, 0));
    endtask

    // Mostly a plausible timeline (notes ending a few beats ahead, windows that
    // follow one another), with some noise commands and broken windows mixed in.
    task automatic test_random_traffic();
        int          sent;
        int          pick;
        logic [31:0] window_end;
        logic [31:0] spb;
        note_cmd_t   c;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case (sent * 4 / RANDOM_ITEMS)
                0: begin
                    src_gap_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_gap_pct = 40;
                    sink_stall_pct = 5;
                end
                2: begin
                    src_gap_pct = 5;
                    sink_stall_pct = 40;
                end
                default: begin
                    src_gap_pct = 25;
                    sink_stall_pct = 25;
                end
            endcase
            spb = ($urandom_range(0, 99) < 70) ? $urandom_range(32'h0006_4000, 32'h0BB8_0000)
                                               : $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                c = make_cmd(OP_UNUSED, 7'($urandom), 4'($urandom), $urandom, $urandom,
                             $urandom, $urandom, $urandom);
            end else if (pick < 56) begin
                c = make_cmd(anos_pkg::OP_ADD, 7'($urandom), 4'($urandom),
                             beat_now + $urandom_range(0, 32'h0006_0000),
                             $urandom, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 99) < 15) begin
                    c.end_beat = $urandom;
                end
            end else if (pick < 93) begin
                window_end = beat_now + $urandom_range(0, 32'h0003_0000);
                c = make_cmd(anos_pkg::OP_ADVANCE, 7'($urandom), 4'($urandom), $urandom,
                             beat_now, window_end, $urandom, spb);
                beat_now = window_end;
                if ($urandom_range(0, 99) < 10) begin
                    c.from_beat = $urandom;
                    c.up_to_beat = $urandom;
                end
            end else begin
                c = make_cmd(anos_pkg::OP_FLUSH, 7'($urandom), 4'($urandom), $urandom,
                             $urandom, $urandom, $urandom, $urandom);
            end
            send_item(c);
            if (c.op != OP_UNUSED) begin
                sent++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = anos_pkg::OP_ADD;
        sounding_count = 0;
        mismatch_count = 0;
        src_gap_pct = 0;
        sink_stall_pct = 0;
        beat_now = $urandom;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_corner_cases();
        test_full_table();
        test_random_traffic();
        s_tvalid = 1'b0;

        // Let the receiver run freely while the last note-offs drain, then watch
        // long enough for a whole table walk to show any stray transfer.
        sink_stall_pct = 0;
        while (note_off_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && note_off_q.size() == 0) begin
            $display("active_note_off_scheduler_core: match");
        end else begin
            $display("active_note_off_scheduler_core: mismatch");
        end
        $finish;
    end

endmodule
